@@ design/ppp_pkg.sv @@
// Shared types and constants for the palette pixel packer.
// No dependencies; imported by the interfaces and the top level.
package ppp_pkg;

	localparam int WORD_BITS      = 32;
	localparam int COUNT_W        = 10;
	localparam int ROW_W          = 9;
	localparam int MAX_ROW_PIXELS = 256;

	// Item command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// Configuration register indexes
	localparam logic REG_ROW_WIDTH    = 1'b0;
	localparam logic REG_DISPLAY_MODE = 1'b1;

	localparam logic [WORD_BITS-1:0] MSB_MASK = 32'h8000_0000;
	localparam logic [WORD_BITS-1:0] LSB_MASK = 32'h0000_0001;

	typedef enum logic [1:0] {
		MODE_MONO_MSB = 2'd0,
		MODE_MONO_LSB = 2'd1,
		MODE_PLANE8   = 2'd2,
		MODE_PLANE32  = 2'd3
	} mode_t;

endpackage

@@ design/ppp_if.sv @@
// Valid/ready channel interfaces for the palette pixel packer.
// Depends on ppp_pkg for the field widths.
interface ppp_in_if import ppp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 cmd;
	logic [COUNT_W-1:0]   count;
	logic [WORD_BITS-1:0] palette_value;

	modport source (output valid, cmd, count, palette_value, input ready);
	modport sink   (input valid, cmd, count, palette_value, output ready);
endinterface

interface ppp_out_if import ppp_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [WORD_BITS-1:0] pixel_word;
	logic                 row_end;

	modport source (output valid, pixel_word, row_end, input ready);
	modport sink   (input valid, pixel_word, row_end, output ready);
endinterface

@@ design/palette_pixel_packer.sv @@
// Palette pixel packer: palette lookup and mono / plane word packing.
// Depends on ppp_pkg and the channel interfaces in ppp_if.sv.
//
// Usage:
//   Items enter on the "items" channel. cmd = write stores palette_value at
//   palette entry count (clamped to the last entry) and gives no result.
//   cmd = pixel looks up its palette entry and, depending on display_mode,
//   either packs one bit into a 32-bit mono word or emits the entry (low
//   byte or whole word) on the "words" channel, with row_end on the last
//   pixel of a row.
//   Configuration (row_width, display_mode) must be written via cfg_we /
//   cfg_index / cfg_data while the block is idle; this is not enforced.
// Timing:
//   One item per cycle sustained while words.ready stays high. A pixel's
//   palette read is registered at the accepting edge (read stage), and the
//   packing logic then loads the output register, when a word is due, as
//   the read stage advances; words.valid is driven by that register.
// Reset:
//   arst_n clears the pipeline, packing state and row position; row_width
//   resets to 32 and display_mode to 8-plane. Palette contents are
//   undefined until written.
// Stall:
//   When words.ready is low the output register holds its item; the read
//   stage and then the input stop accepting once both are full.
module palette_pixel_packer import ppp_pkg::*; #(
	parameter int PALETTE_ENTRIES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [ROW_W-1:0]           cfg_data,
	ppp_in_if.sink                     items,
	ppp_out_if.source                  words
);

	localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	logic [WORD_BITS-1:0] palette_mem [PALETTE_ENTRIES];

	logic [ROW_W-1:0]     row_width_q;
	mode_t                mode_q;
	logic [ROW_W-1:0]     col_q;
	logic [WORD_BITS-1:0] pack_q;
	logic [4:0]           bp_q;

	logic                 valid_s1;
	logic [WORD_BITS-1:0] rd_s1;

	logic                 out_valid_q;
	logic [WORD_BITS-1:0] out_word_q;
	logic                 out_end_q;

	logic                 accept;
	logic [IDX_W-1:0]     idx;
	logic                 out_free;
	logic                 adv_s1;
	logic                 mono;
	logic [ROW_W:0]       eff_width;
	logic [ROW_W:0]       col_inc;
	logic                 last;
	logic [WORD_BITS-1:0] pack_set;
	logic                 emit;
	logic [WORD_BITS-1:0] emit_word;

	// Handshake and stage advance
	assign out_free     = !out_valid_q || words.ready;
	assign adv_s1       = valid_s1 && (!emit || out_free);
	assign items.ready  = !valid_s1 || adv_s1;
	assign accept       = items.valid && items.ready;

	// Clamp the palette index to the last entry
	always_comb begin
		if ({22'd0, items.count} >= 32'(PALETTE_ENTRIES))
			idx = IDX_W'(PALETTE_ENTRIES - 1);
		else
			idx = IDX_W'(items.count);
	end

	// Palette memory: write on accept, registered read for pixels
	always_ff @(posedge clk) begin
		if (accept && items.cmd == CMD_WRITE)
			palette_mem[idx] <= items.palette_value;
		if (accept && items.cmd == CMD_PIXEL)
			rd_s1 <= palette_mem[idx];
	end

	// Effective row width: zero acts as one, clamp to the row maximum
	always_comb begin
		if (row_width_q == '0)
			eff_width = (ROW_W+1)'(1);
		else if ({23'd0, row_width_q} > 32'(MAX_ROW_PIXELS))
			eff_width = (ROW_W+1)'(MAX_ROW_PIXELS);
		else
			eff_width = {1'b0, row_width_q};
	end

	assign col_inc = {1'b0, col_q} + (ROW_W+1)'(1);
	assign last    = col_inc >= eff_width;
	assign mono    = (mode_q == MODE_MONO_MSB) || (mode_q == MODE_MONO_LSB);

	// Pack or pass the entry
	always_comb begin
		pack_set = pack_q;
		if (rd_s1 != '0) begin
			if (mode_q == MODE_MONO_MSB)
				pack_set = pack_q | (MSB_MASK >> bp_q);
			else
				pack_set = pack_q | (LSB_MASK << bp_q);
		end
		unique case (mode_q)
			MODE_MONO_MSB, MODE_MONO_LSB: begin
				emit      = (bp_q == 5'd31) || last;
				emit_word = pack_set;
			end
			MODE_PLANE8: begin
				emit      = 1'b1;
				emit_word = {24'd0, rd_s1[7:0]};
			end
			default: begin
				emit      = 1'b1;
				emit_word = rd_s1;
			end
		endcase
	end

	// Control state, configuration and packing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			row_width_q <= ROW_W'(32);
			mode_q      <= MODE_PLANE8;
			col_q       <= '0;
			pack_q      <= '0;
			bp_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROW_WIDTH:    row_width_q <= cfg_data;
					REG_DISPLAY_MODE: mode_q      <= mode_t'(cfg_data[1:0]);
					default:          ;
				endcase
			end
			if (items.ready)
				valid_s1 <= accept && items.cmd == CMD_PIXEL;
			if (out_free)
				out_valid_q <= 1'b0;
			if (adv_s1) begin
				col_q <= last ? '0 : col_inc[ROW_W-1:0];
				if (emit) begin
					out_valid_q <= 1'b1;
					pack_q      <= '0;
					bp_q        <= '0;
				end else begin
					pack_q <= pack_set;
					bp_q   <= bp_q + 5'd1;
				end
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			out_word_q <= emit_word;
			out_end_q  <= last;
		end
	end

	assign words.valid      = out_valid_q;
	assign words.pixel_word = out_word_q;
	assign words.row_end    = out_end_q;

	// A plane-mode pixel always leaves the mono packer empty
	a_plane_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !mono) |=> (bp_q == '0 && pack_q == '0))
		else $error("packing state not cleared by plane pixel");

	// The pixel that ends a row restarts the column count
	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last) |=> (col_q == '0 && out_valid_q && out_end_q))
		else $error("row end did not restart column count");

	// A stalled read stage keeps its palette data
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(rd_s1)))
		else $error("read stage lost its item while stalled");

	// A result is never overwritten before it is taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !words.ready) |=> (out_valid_q && $stable(out_word_q)))
		else $error("output item overwritten while stalled");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for palette_pixel_packer: palette loads, plane and mono pixels.
// Keeps its own palette and packing state, and checks each output word against it.
// Depends on ppp_pkg, the channel interfaces in ppp_if.sv and the design top level.
module tb_top import ppp_pkg::*; ();

	localparam int PAL_ENTRIES  = 1024;
	localparam int DRAIN_CYCLES = 6;
	localparam int RANDOM_ITEMS = 600;

	typedef struct packed {
		logic [WORD_BITS-1:0] pixel_word;
		logic                 row_end;
	} word_result_t;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic            cfg_index;
	logic [ROW_W-1:0] cfg_data;

	ppp_in_if  items_ch ();
	ppp_out_if words_ch ();

	palette_pixel_packer #(.PALETTE_ENTRIES(PAL_ENTRIES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (items_ch),
		.words     (words_ch)
	);

	// Shadow of the block: palette, row position, mono accumulator, registers
	logic [WORD_BITS-1:0] palette_shadow [PAL_ENTRIES];
	bit                   palette_loaded [PAL_ENTRIES];
	int                   loaded_indexes [$];
	int                   col_pos;
	logic [WORD_BITS-1:0] mono_acc;
	int                   mono_fill;
	logic [ROW_W-1:0]     width_shadow;
	mode_t                mode_shadow;

	word_result_t expected_words [$];
	int           mismatch_count;
	int           random_sent;
	bit           steady;    // no idling on either side while set

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Output back-pressure
	initial begin
		words_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			words_ch.ready = steady ? 1'b1 : ($urandom_range(99) >= 15);
		end
	end

	// Result checker
	always @(posedge clk) begin
		word_result_t want;
		if (arst_n && words_ch.valid && words_ch.ready) begin
			if (expected_words.size() == 0) begin
				$error("unexpected word: pixel_word %h row_end %b",
					words_ch.pixel_word, words_ch.row_end);
				mismatch_count++;
			end else begin
				want = expected_words.pop_front();
				if (words_ch.pixel_word !== want.pixel_word) begin
					$error("pixel_word: expected %h, got %h", want.pixel_word,
						words_ch.pixel_word);
					mismatch_count++;
				end
				if (words_ch.row_end !== want.row_end) begin
					$error("row_end: expected %b, got %b", want.row_end,
						words_ch.row_end);
					mismatch_count++;
				end
			end
		end
	end

	function automatic int clamp_index(logic [COUNT_W-1:0] count);
		return (int'(count) >= PAL_ENTRIES) ? PAL_ENTRIES - 1 : int'(count);
	endfunction

	function automatic void store_palette(logic [COUNT_W-1:0] count, logic [WORD_BITS-1:0] value);
		int idx;
		idx = clamp_index(count);
		palette_shadow[idx] = value;
		if (!palette_loaded[idx]) begin
			palette_loaded[idx] = 1'b1;
			loaded_indexes.push_back(idx);
		end
	endfunction

	// One pixel: palette lookup, row position, then mono packing or plane output
	function automatic void pack_pixel(logic [COUNT_W-1:0] count);
		logic [WORD_BITS-1:0] entry;
		int                   w;
		bit                   last;
		word_result_t         res;
		entry = palette_shadow[clamp_index(count)];
		w = int'(width_shadow);
		if (w == 0)
			w = 1;
		else if (w > MAX_ROW_PIXELS)
			w = MAX_ROW_PIXELS;
		last = (col_pos + 1) >= w;
		col_pos = last ? 0 : col_pos + 1;
		if (mode_shadow == MODE_MONO_MSB || mode_shadow == MODE_MONO_LSB) begin
			if (entry != '0) begin
				if (mode_shadow == MODE_MONO_MSB)
					mono_acc |= MSB_MASK >> mono_fill;
				else
					mono_acc |= LSB_MASK << mono_fill;
			end
			mono_fill++;
			if (mono_fill >= WORD_BITS || last) begin
				res.pixel_word = mono_acc;
				res.row_end = last;
				expected_words.push_back(res);
				mono_acc = '0;
				mono_fill = 0;
			end
		end else begin
			// a plane pixel drops any partly packed mono word
			mono_acc = '0;
			mono_fill = 0;
			res.pixel_word = (mode_shadow == MODE_PLANE8) ? {24'd0, entry[7:0]} : entry;
			res.row_end = last;
			expected_words.push_back(res);
		end
	endfunction

	// Send one item; called and returns at a falling edge with valid still high
	task automatic send_item(logic cmd, logic [COUNT_W-1:0] count, logic [WORD_BITS-1:0] value);
		if (!steady) begin
			while ($urandom_range(99) < 15) begin
				items_ch.valid = 1'b0;
				@(negedge clk);
			end
		end
		items_ch.valid = 1'b1;
		items_ch.cmd = cmd;
		items_ch.count = count;
		items_ch.palette_value = value;
		do
			@(posedge clk);
		while (!items_ch.ready);
		if (cmd == CMD_WRITE)
			store_palette(count, value);
		else
			pack_pixel(count);
		@(negedge clk);
	endtask

	task automatic write_palette(logic [COUNT_W-1:0] idx, logic [WORD_BITS-1:0] value);
		send_item(CMD_WRITE, idx, value);
	endtask

	task automatic send_pixel(logic [COUNT_W-1:0] count);
		send_item(CMD_PIXEL, count, $urandom);
	endtask

	// Stop sending and let every word and in-flight item drain out
	task automatic drain();
		items_ch.valid = 1'b0;
		while (expected_words.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [ROW_W-1:0] data);
		drain();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_ROW_WIDTH)
			width_shadow = data;
		else
			mode_shadow = mode_t'(data[1:0]);
	endtask

	task automatic set_config(logic [ROW_W-1:0] width, mode_t mode);
		write_reg(REG_ROW_WIDTH, width);
		write_reg(REG_DISPLAY_MODE, ROW_W'(mode));
	endtask

	// Palette extremes, alternating patterns and zero entries
	task automatic test_palette_load();
		write_palette(10'd0, 32'h0000_0000);
		write_palette(10'd1, 32'h0000_0001);
		write_palette(10'd1023, 32'hFFFF_FFFF);
		write_palette(10'd512, 32'h8000_0000);
		write_palette(10'd341, 32'hAAAA_AAAA);
		write_palette(10'd682, 32'h5555_5555);
		write_palette(10'd3, 32'h1234_5678);
		write_palette(10'd4, 32'h0000_0000);
	endtask

	// Reset configuration (8-plane, width 32), then 32-plane with short rows
	task automatic test_plane_pixels();
		send_pixel(10'd1023);
		send_pixel(10'd341);
		set_config(9'd2, MODE_PLANE32);
		send_pixel(10'd512);
		send_pixel(10'd682);
	endtask

	// Mono rows: width zero acts as one, then a short LSB-first row
	task automatic test_mono_rows();
		set_config(9'd0, MODE_MONO_MSB);
		send_pixel(10'd1);
		send_pixel(10'd4);
		set_config(9'd3, MODE_MONO_LSB);
		send_pixel(10'd1023);
		send_pixel(10'd0);
		send_pixel(10'd1);
	endtask

	// Partial mono word dropped by a plane pixel; row width lowered mid-row
	task automatic test_mode_switch();
		set_config(9'd511, MODE_MONO_LSB);
		send_pixel(10'd3);
		send_pixel(10'd512);
		write_reg(REG_DISPLAY_MODE, ROW_W'(MODE_PLANE8));
		send_pixel(10'd3);
		set_config(9'd8, MODE_PLANE32);
		send_pixel(10'd1);
		send_pixel(10'd3);
		send_pixel(10'd4);
		write_reg(REG_ROW_WIDTH, 9'd2);
		send_pixel(10'd682);
		send_pixel(10'd1023);
	endtask

	function automatic logic [ROW_W-1:0] pick_width();
		case ($urandom_range(9))
			0: return 9'd0;
			1: return 9'd1;
			2: return 9'd256;
			3: return ROW_W'($urandom_range(511, 257));
			4: return ROW_W'($urandom_range(33, 31));
			default: return ROW_W'($urandom_range(256, 1));
		endcase
	endfunction

	function automatic logic [WORD_BITS-1:0] pick_value();
		case ($urandom_range(3))
			0: return '0;
			1: return LSB_MASK << $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	// Phases of random rows under random configuration; mostly pixels
	task automatic test_random_rows();
		int phase;
		int n;
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			steady = (phase == 3);
			if ($urandom_range(1))
				set_config(pick_width(), mode_t'($urandom_range(3)));
			else
				write_reg($urandom_range(1) ? REG_ROW_WIDTH : REG_DISPLAY_MODE,
					$urandom_range(1) ? pick_width() : ROW_W'($urandom_range(3)));
			n = (phase == 3) ? 120 : $urandom_range(70, 20);
			repeat (n) begin
				if ($urandom_range(99) < 12)
					write_palette(COUNT_W'($urandom_range(PAL_ENTRIES - 1)), pick_value());
				else
					send_pixel(COUNT_W'(loaded_indexes[
						$urandom_range(loaded_indexes.size() - 1)]));
				random_sent++;
			end
			phase++;
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ROW_WIDTH;
		cfg_data = '0;
		items_ch.valid = 1'b0;
		items_ch.cmd = CMD_WRITE;
		items_ch.count = '0;
		items_ch.palette_value = '0;
		steady = 1'b0;
		mismatch_count = 0;
		random_sent = 0;
		col_pos = 0;
		mono_acc = '0;
		mono_fill = 0;
		width_shadow = 9'd32;
		mode_shadow = MODE_PLANE8;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_palette_load();
		test_plane_pixels();
		test_mono_rows();
		test_mode_switch();
		test_random_rows();
		drain();

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ files.f @@
design/ppp_pkg.sv
design/ppp_if.sv
design/palette_pixel_packer.sv
test/tb_top.sv
